### design/msip_pkg.sv
// Shared widths, codes and constants for the move step-interval planner.
// No dependencies; every other file of the block imports this package.
package msip_pkg;

  // Stream payload widths.
  localparam int InDataW  = 120;
  localparam int InUserW  = 2;
  localparam int OutDataW = 128;
  localparam int OutUserW = 1;

  // Configuration port.
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 24;

  // Field widths.
  localparam int CoordW    = 32;
  localparam int FeedW     = 20;
  localparam int ScaleW    = 24;
  localparam int IntervalW = 26;

  // Serial arithmetic units.
  localparam int MulAW    = 64;
  localparam int MulBW    = 25;
  localparam int MulCntW  = 5;
  localparam int DivW     = 37;
  localparam int DivCntW  = 6;
  localparam int RootInW  = 34;
  localparam int RootW    = 17;
  localparam int RootCntW = 5;

  // Command codes.
  localparam logic [1:0] CmdLinear = 2'd0;
  localparam logic [1:0] CmdRapid  = 2'd1;
  localparam logic [1:0] CmdSetPos = 2'd2;

  // Result kinds.
  localparam logic KindMove   = 1'b0;
  localparam logic KindSetPos = 1'b1;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] RegMaxFeedXy = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMaxFeedZ  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegStepsXy   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegStepsZ    = 2'd3;

  // Register reset values.
  localparam logic [FeedW-1:0]  MaxFeedXyRst = 20'd5000;
  localparam logic [FeedW-1:0]  MaxFeedZRst  = 20'd150;
  localparam logic [ScaleW-1:0] StepsXyRst   = 24'd48188;
  localparam logic [ScaleW-1:0] StepsZRst    = 24'd81920;

  // Arithmetic constants.
  localparam logic [DivW-1:0]  UsecPerMin = 37'd60000000;
  localparam logic [DivW-1:0]  InvNum     = 37'd16777216;
  localparam logic [RootW-1:0] PartOne    = 17'd65536;
  localparam logic [16:0]      ShortSum   = 17'd256;

endpackage

### design/msip_mul.sv
// Radix-2 shift-and-add multiplier: one multiplier bit per cycle.
// Depends on msip_pkg for operand widths.
module msip_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [msip_pkg::MulAW-1:0]   a,
  input  logic [msip_pkg::MulBW-1:0]   b,
  output logic                         done,
  output logic [msip_pkg::MulAW-1:0]   p
);
  import msip_pkg::*;

  logic [MulAW-1:0]   acc;
  logic [MulAW-1:0]   mcand;
  logic [MulBW-1:0]   mplier;
  logic [MulCntW-1:0] cnt;
  logic               run;

  // The multiplicand may be a sign-extended value; wrapping at 64 bits keeps
  // the two's complement product exact for every operand used here.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= MulCntW'(MulBW);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == MulCntW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= a;
      mplier <= b;
    end else if (run) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= {mcand[MulAW-2:0], 1'b0};
      mplier <= {1'b0, mplier[MulBW-1:1]};
    end
  end

  assign p = acc;

endmodule

### design/msip_div.sv
// Restoring divider: one quotient bit per cycle.
// Depends on msip_pkg for widths; the divisor must not be zero.
module msip_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [msip_pkg::DivW-1:0]  n,
  input  logic [msip_pkg::DivW-1:0]  d,
  output logic                       done,
  output logic [msip_pkg::DivW-1:0]  q
);
  import msip_pkg::*;

  logic [DivW-1:0]    rem;
  logic [DivW-1:0]    quo;
  logic [DivW-1:0]    dsr;
  logic [DivCntW-1:0] cnt;
  logic               run;
  logic [DivW:0]      trial;
  logic               fits;

  assign trial = {rem, quo[DivW-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= DivCntW'(DivW);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == DivCntW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The dividend shifts out of the top of quo while quotient bits enter below.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= n;
      dsr <= d;
    end else if (run) begin
      if (fits) begin
        rem <= DivW'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[DivW-1:0];
      end
      quo <= {quo[DivW-2:0], fits};
    end
  end

  assign q = quo;

endmodule

### design/msip_root.sv
// Digit-by-digit integer square root: two radicand bits per cycle.
// Depends on msip_pkg for widths; gives the floor of the root.
module msip_root (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [msip_pkg::RootInW-1:0]  v,
  output logic                          done,
  output logic [msip_pkg::RootW-1:0]    r
);
  import msip_pkg::*;

  logic [RootInW-1:0]  rad;
  logic [RootW+2:0]    rem;
  logic [RootW-1:0]    root;
  logic [RootCntW-1:0] cnt;
  logic                run;
  logic [RootW+2:0]    rem_sh;
  logic [RootW+2:0]    trial;
  logic                fits;

  // The remainder never exceeds twice the partial root, so 18 bits carry it.
  assign rem_sh = {rem[RootW:0], rad[RootInW-1:RootInW-2]};
  assign trial  = {1'b0, root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= RootCntW'(RootW);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == RootCntW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= v;
      rem  <= '0;
      root <= '0;
    end else if (run) begin
      rad  <= {rad[RootInW-3:0], 2'b00};
      rem  <= fits ? rem_sh - trial : rem_sh;
      root <= {root[RootW-2:0], fits};
    end
  end

  assign r = root;

endmodule

### design/move_step_interval_planner_unit.sv
// Move step-interval planner: turns target points into absolute step counts
// and a step interval. Depends on msip_pkg, msip_mul, msip_div and msip_root.
//
// Usage: an input transaction on the s_ channel carries a command in s_tuser
// and a target point with a feedrate in s_tdata. Each input gives exactly one
// output transaction on the m_ channel: the kind in m_tuser and the absolute
// step positions with the step interval in microseconds in m_tdata.
// Configuration writes on the cfg_ channel are always taken (cfg_ready is
// high) and should only be issued while the block is idle.
// One item is worked on at a time. A set-position command needs three
// step-count products from acceptance to the result; a move needs more,
// from a single-axis move up to a move with root, clamps and three axis
// rates. The work is done by the shared radix-2 multiplier, the
// one-bit-per-cycle divider and the root unit. The next input is accepted
// in the cycle after the result is loaded.
// The result sits in an output register; the next input is accepted while it
// waits for m_tready, and a stalled receiver only holds the block at the end
// of the following item. Reset loads the default feed limits and step
// scales, sets the previous point to zero and empties the output register.
module move_step_interval_planner_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // target_x [31:0], target_y [63:32], target_z [95:64], feed_rate [115:96]
  input  logic [msip_pkg::InDataW-1:0]     s_tdata,
  // cmd [1:0]
  input  logic [msip_pkg::InUserW-1:0]     s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // step_x [31:0], step_y [63:32], step_z [95:64], step_interval_us [121:96]
  output logic [msip_pkg::OutDataW-1:0]    m_tdata,
  // kind [0]
  output logic [msip_pkg::OutUserW-1:0]    m_tuser,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [msip_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [msip_pkg::CfgDataW-1:0]    cfg_data
);
  import msip_pkg::*;

  typedef enum logic [30:0] {
    ST_IDLE  = 31'd1 << 0,
    ST_STX   = 31'd1 << 1,
    ST_STY   = 31'd1 << 2,
    ST_STZ   = 31'd1 << 3,
    ST_DELTA = 31'd1 << 4,
    ST_NORM  = 31'd1 << 5,
    ST_CLASS = 31'd1 << 6,
    ST_SGL   = 31'd1 << 7,
    ST_ZM    = 31'd1 << 8,
    ST_SQX   = 31'd1 << 9,
    ST_SQY   = 31'd1 << 10,
    ST_SQZ   = 31'd1 << 11,
    ST_ROOT  = 31'd1 << 12,
    ST_INV   = 31'd1 << 13,
    ST_PX    = 31'd1 << 14,
    ST_PY    = 31'd1 << 15,
    ST_PZ    = 31'd1 << 16,
    ST_CZM   = 31'd1 << 17,
    ST_CZD   = 31'd1 << 18,
    ST_CYM   = 31'd1 << 19,
    ST_CYD   = 31'd1 << 20,
    ST_CXM   = 31'd1 << 21,
    ST_CXD   = 31'd1 << 22,
    ST_RXM   = 31'd1 << 23,
    ST_RXS   = 31'd1 << 24,
    ST_RYM   = 31'd1 << 25,
    ST_RYS   = 31'd1 << 26,
    ST_RZM   = 31'd1 << 27,
    ST_RZS   = 31'd1 << 28,
    ST_FDIV  = 31'd1 << 29,
    ST_OUT   = 31'd1 << 30
  } state_t;

  state_t state;

  // Configuration registers.
  logic [FeedW-1:0]  max_feed_xy;
  logic [FeedW-1:0]  max_feed_z;
  logic [ScaleW-1:0] steps_xy;
  logic [ScaleW-1:0] steps_z;

  // Previous point and the item at work.
  logic [CoordW-1:0]    last_x, last_y, last_z;
  logic [1:0]           cmd;
  logic [CoordW-1:0]    tx, ty, tz;
  logic [FeedW-1:0]     feed_in;
  logic [FeedW-1:0]     feed;
  logic [CoordW-1:0]    sx, sy, sz;
  logic [CoordW:0]      dx, dy, dz;
  logic [RootInW-1:0]   sum;
  logic [RootW-1:0]     dist_root;
  logic [MulBW-1:0]     inv;
  logic [RootW-1:0]     px, py, pz;
  logic [FeedW:0]       part_feed;
  logic [DivW-1:0]      best;
  logic [IntervalW-1:0] interval;
  logic                 issued;

  // Output register.
  logic [OutDataW-1:0] out_data;
  logic [OutUserW-1:0] out_user;

  // Shared arithmetic units.
  logic              mul_req, mul_go, mul_done;
  logic [MulAW-1:0]  mul_a, mul_p;
  logic [MulBW-1:0]  mul_b;
  logic              div_req, div_go, div_done;
  logic [DivW-1:0]   div_n, div_d, div_q;
  logic              root_go, root_done;
  logic [RootW-1:0]  root_r;

  // Combinational helpers.
  logic [FeedW-1:0]  feed_max;
  logic [FeedW+1:0]  rapid_x3;
  logic [FeedW-1:0]  feed_pick;
  logic [CoordW:0]   diff_x, diff_y, diff_z;
  logic [16:0]       dxy_sum;
  logic              short_xy;
  logic [CoordW:0]   rate_xy;
  logic [DivW-1:0]   rate_z;
  logic [RootW-1:0]  pz_new;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tdata   = out_data;
  assign m_tuser   = out_user;

  assign feed_max  = (max_feed_xy > max_feed_z) ? max_feed_xy : max_feed_z;
  assign rapid_x3  = {1'b0, feed_max, 1'b0} + {2'b00, feed_max};
  assign feed_pick = (cmd == CmdRapid) ? rapid_x3[FeedW+1:2] : feed_in;

  assign diff_x = {tx[CoordW-1], tx} - {last_x[CoordW-1], last_x};
  assign diff_y = {ty[CoordW-1], ty} - {last_y[CoordW-1], last_y};
  assign diff_z = {tz[CoordW-1], tz} - {last_z[CoordW-1], last_z};

  assign dxy_sum  = {1'b0, dx[15:0]} + {1'b0, dy[15:0]};
  assign short_xy = (dz == '0) && ((dx == '0) || (dy == '0) || (dxy_sum < ShortSum));

  assign rate_xy = mul_p[44:12];
  assign rate_z  = mul_p[44:8];
  assign pz_new  = mul_p[24:8];

  always_comb begin
    mul_req = 1'b0;
    div_req = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    div_n   = '0;
    div_d   = '0;
    case (state)
      ST_STX: begin
        mul_req = 1'b1;
        mul_a   = {{36{tx[CoordW-1]}}, tx[CoordW-1:4]};
        mul_b   = MulBW'(steps_xy[ScaleW-1:2]);
      end
      ST_STY: begin
        mul_req = 1'b1;
        mul_a   = {{36{ty[CoordW-1]}}, ty[CoordW-1:4]};
        mul_b   = MulBW'(steps_xy[ScaleW-1:2]);
      end
      ST_STZ: begin
        mul_req = 1'b1;
        mul_a   = {{36{tz[CoordW-1]}}, tz[CoordW-1:4]};
        mul_b   = MulBW'(steps_z);
      end
      ST_SGL: begin
        mul_req = 1'b1;
        mul_a   = MulAW'(feed);
        mul_b   = MulBW'(steps_xy[ScaleW-1:4]);
      end
      ST_ZM: begin
        mul_req = 1'b1;
        mul_a   = MulAW'(feed);
        mul_b   = MulBW'(steps_z);
      end
      ST_SQX: begin
        mul_req = 1'b1;
        mul_a   = MulAW'(dx[15:0]);
        mul_b   = MulBW'(dx[15:0]);
      end
      ST_SQY: begin
        mul_req = 1'b1;
        mul_a   = MulAW'(dy[15:0]);
        mul_b   = MulBW'(dy[15:0]);
      end
      ST_SQZ: begin
        mul_req = 1'b1;
        mul_a   = MulAW'(dz[15:0]);
        mul_b   = MulBW'(dz[15:0]);
      end
      ST_INV: begin
        div_req = 1'b1;
        div_n   = InvNum;
        div_d   = DivW'(dist_root);
      end
      ST_PX: begin
        mul_req = 1'b1;
        mul_a   = MulAW'(dx[15:0]);
        mul_b   = inv;
      end
      ST_PY: begin
        mul_req = 1'b1;
        mul_a   = MulAW'(dy[15:0]);
        mul_b   = inv;
      end
      ST_PZ: begin
        mul_req = 1'b1;
        mul_a   = MulAW'(dz[15:0]);
        mul_b   = inv;
      end
      ST_CZM: begin
        mul_req = 1'b1;
        mul_a   = MulAW'(feed);
        mul_b   = MulBW'(pz);
      end
      ST_CZD: begin
        div_req = 1'b1;
        div_n   = {1'b0, max_feed_z, 16'd0};
        div_d   = (pz == '0) ? DivW'(1) : DivW'(pz);
      end
      ST_CYM: begin
        mul_req = 1'b1;
        mul_a   = MulAW'(feed);
        mul_b   = MulBW'(py);
      end
      ST_CYD: begin
        div_req = 1'b1;
        div_n   = {1'b0, max_feed_xy, 16'd0};
        div_d   = (py == '0) ? DivW'(1) : DivW'(py);
      end
      ST_CXM: begin
        mul_req = 1'b1;
        mul_a   = MulAW'(feed);
        mul_b   = MulBW'(px);
      end
      ST_CXD: begin
        div_req = 1'b1;
        div_n   = {1'b0, max_feed_xy, 16'd0};
        div_d   = (px == '0) ? DivW'(1) : DivW'(px);
      end
      ST_RXM: begin
        mul_req = 1'b1;
        mul_a   = MulAW'(feed);
        mul_b   = MulBW'(px);
      end
      ST_RYM: begin
        mul_req = 1'b1;
        mul_a   = MulAW'(feed);
        mul_b   = MulBW'(py);
      end
      ST_RZM: begin
        mul_req = 1'b1;
        mul_a   = MulAW'(feed);
        mul_b   = MulBW'(pz);
      end
      ST_RXS, ST_RYS: begin
        mul_req = 1'b1;
        mul_a   = MulAW'(part_feed);
        mul_b   = MulBW'(steps_xy);
      end
      ST_RZS: begin
        mul_req = 1'b1;
        mul_a   = MulAW'(part_feed);
        mul_b   = MulBW'(steps_z);
      end
      ST_FDIV: begin
        div_req = 1'b1;
        div_n   = UsecPerMin;
        div_d   = (best == '0) ? DivW'(1) : best;
      end
      default: begin
      end
    endcase
  end

  assign mul_go  = mul_req && !issued;
  assign div_go  = div_req && !issued;
  assign root_go = (state == ST_ROOT) && !issued;

  msip_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  msip_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .n     (div_n),
    .d     (div_d),
    .done  (div_done),
    .q     (div_q)
  );

  msip_root u_root (
    .clk   (clk),
    .rst   (rst),
    .start (root_go),
    .v     (sum),
    .done  (root_done),
    .r     (root_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      issued      <= 1'b0;
      m_tvalid    <= 1'b0;
      last_x      <= '0;
      last_y      <= '0;
      last_z      <= '0;
      max_feed_xy <= MaxFeedXyRst;
      max_feed_z  <= MaxFeedZRst;
      steps_xy    <= StepsXyRst;
      steps_z     <= StepsZRst;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          RegMaxFeedXy: max_feed_xy <= cfg_data[FeedW-1:0];
          RegMaxFeedZ:  max_feed_z  <= cfg_data[FeedW-1:0];
          RegStepsXy:   steps_xy    <= cfg_data;
          RegStepsZ:    steps_z     <= cfg_data;
          default: begin
          end
        endcase
      end

      if ((state == ST_OUT) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (mul_go || div_go || root_go) begin
        issued <= 1'b1;
      end else if (mul_done || div_done || root_done) begin
        issued <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            cmd     <= s_tuser;
            tx      <= s_tdata[31:0];
            ty      <= s_tdata[63:32];
            tz      <= s_tdata[95:64];
            feed_in <= s_tdata[115:96];
            state   <= ST_STX;
          end
        end
        ST_STX: begin
          if (mul_done) begin
            sx    <= mul_p[45:14];
            state <= ST_STY;
          end
        end
        ST_STY: begin
          if (mul_done) begin
            sy    <= mul_p[45:14];
            state <= ST_STZ;
          end
        end
        ST_STZ: begin
          if (mul_done) begin
            sz <= mul_p[43:12];
            if (cmd == CmdSetPos) begin
              interval <= '0;
              state    <= ST_OUT;
            end else begin
              state <= ST_DELTA;
            end
          end
        end
        ST_DELTA: begin
          feed  <= (feed_pick == '0) ? FeedW'(1) : feed_pick;
          dx    <= diff_x[CoordW] ? -diff_x : diff_x;
          dy    <= diff_y[CoordW] ? -diff_y : diff_y;
          dz    <= diff_z[CoordW] ? -diff_z : diff_z;
          state <= ST_NORM;
        end
        ST_NORM: begin
          // Scale all deltas together until each fits in 16 bits.
          if ((|dx[CoordW:16]) || (|dy[CoordW:16]) || (|dz[CoordW:16])) begin
            dx <= {4'd0, dx[CoordW:4]};
            dy <= {4'd0, dy[CoordW:4]};
            dz <= {4'd0, dz[CoordW:4]};
          end else begin
            state <= ST_CLASS;
          end
        end
        ST_CLASS: begin
          if (short_xy) begin
            if (feed > max_feed_xy) begin
              feed <= max_feed_xy;
            end
            state <= ST_SGL;
          end else if ((dx == '0) && (dy == '0)) begin
            if (feed > max_feed_z) begin
              feed <= max_feed_z;
            end
            state <= ST_ZM;
          end else begin
            state <= ST_SQX;
          end
        end
        ST_SGL: begin
          if (mul_done) begin
            best  <= DivW'(mul_p[39:8]);
            state <= ST_FDIV;
          end
        end
        ST_ZM: begin
          if (mul_done) begin
            best  <= DivW'(mul_p[43:8]);
            state <= ST_FDIV;
          end
        end
        ST_SQX: begin
          if (mul_done) begin
            sum   <= mul_p[RootInW-1:0];
            state <= ST_SQY;
          end
        end
        ST_SQY: begin
          if (mul_done) begin
            sum   <= sum + mul_p[RootInW-1:0];
            state <= ST_SQZ;
          end
        end
        ST_SQZ: begin
          if (mul_done) begin
            sum   <= sum + mul_p[RootInW-1:0];
            state <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          if (root_done) begin
            dist_root <= (root_r == '0) ? RootW'(1) : root_r;
            state     <= ST_INV;
          end
        end
        ST_INV: begin
          if (div_done) begin
            inv   <= (div_q == '0) ? MulBW'(1) : div_q[MulBW-1:0];
            state <= ST_PX;
          end
        end
        ST_PX: begin
          if (mul_done) begin
            px    <= mul_p[24:8];
            state <= ST_PY;
          end
        end
        ST_PY: begin
          if (mul_done) begin
            py    <= mul_p[24:8];
            state <= ST_PZ;
          end
        end
        ST_PZ: begin
          if (mul_done) begin
            pz <= pz_new;
            if ((px == '0) && (py == '0) && (pz_new == '0)) begin
              px <= PartOne;
            end
            state <= ST_CZM;
          end
        end
        ST_CZM: begin
          if (mul_done) begin
            state <= (mul_p[MulAW-1:16] > 48'(max_feed_z)) ? ST_CZD : ST_CYM;
          end
        end
        ST_CZD: begin
          if (div_done) begin
            feed  <= div_q[FeedW-1:0];
            state <= ST_CYM;
          end
        end
        ST_CYM: begin
          if (mul_done) begin
            state <= (mul_p[MulAW-1:16] > 48'(max_feed_xy)) ? ST_CYD : ST_CXM;
          end
        end
        ST_CYD: begin
          if (div_done) begin
            feed  <= div_q[FeedW-1:0];
            state <= ST_CXM;
          end
        end
        ST_CXM: begin
          if (mul_done) begin
            state <= (mul_p[MulAW-1:16] > 48'(max_feed_xy)) ? ST_CXD : ST_RXM;
          end
        end
        ST_CXD: begin
          if (div_done) begin
            feed  <= div_q[FeedW-1:0];
            state <= ST_RXM;
          end
        end
        ST_RXM: begin
          if (mul_done) begin
            part_feed <= mul_p[36:16];
            state     <= ST_RXS;
          end
        end
        ST_RXS: begin
          if (mul_done) begin
            best  <= DivW'(rate_xy);
            state <= ST_RYM;
          end
        end
        ST_RYM: begin
          if (mul_done) begin
            part_feed <= mul_p[36:16];
            state     <= ST_RYS;
          end
        end
        ST_RYS: begin
          if (mul_done) begin
            if (DivW'(rate_xy) > best) begin
              best <= DivW'(rate_xy);
            end
            state <= ST_RZM;
          end
        end
        ST_RZM: begin
          if (mul_done) begin
            part_feed <= mul_p[36:16];
            state     <= ST_RZS;
          end
        end
        ST_RZS: begin
          if (mul_done) begin
            if (rate_z > best) begin
              best <= rate_z;
            end
            state <= ST_FDIV;
          end
        end
        ST_FDIV: begin
          if (div_done) begin
            interval <= (div_q == '0) ? IntervalW'(1) : div_q[IntervalW-1:0];
            state    <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            out_data <= {6'd0, interval, sz, sy, sx};
            out_user <= (cmd == CmdSetPos) ? KindSetPos : KindMove;
            last_x   <= tx;
            last_y   <= ty;
            last_z   <= tz;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### test/move_step_interval_planner_unit_test.sv
// Self-checking testbench for the move step-interval planner unit.
// Depends on msip_pkg and move_step_interval_planner_unit; it predicts every
// result in SystemVerilog and checks it against the output stream.
`timescale 1ns / 1ps

module move_step_interval_planner_unit_test;
  import msip_pkg::*;

  // Fields from the highest bit down, so the packed value lines up with
  // {m_tuser[0], m_tdata[121:0]}.
  typedef struct packed {
    logic                 kind;
    logic [IntervalW-1:0] interval;
    logic [CoordW-1:0]    step_z;
    logic [CoordW-1:0]    step_y;
    logic [CoordW-1:0]    step_x;
  } step_result_t;

  localparam int IdleLimit = 20000;
  // The unused command code behaves as a linear move.
  localparam logic [1:0] CmdSpare = 2'd3;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;
  logic [InUserW-1:0]  s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;
  logic [OutUserW-1:0] m_tuser;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  // Predictor state: configuration and previous point.
  longint unsigned feed_xy_lim, feed_z_lim, scale_xy, scale_z;
  logic signed [CoordW-1:0] prev_x, prev_y, prev_z;
  // Stimulus generator's own idea of the current position.
  logic signed [CoordW-1:0] gen_x, gen_y, gen_z;

  step_result_t expected_steps[$];
  int error_count = 0;
  int idle_cycles = 0;
  int stall_request = 0;

  move_step_interval_planner_unit u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= r + bitv) begin
        v = v - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned safe_div(longint unsigned n, longint unsigned d);
    return n / ((d == 0) ? 64'd1 : d);
  endfunction

  function automatic longint unsigned axis_delta(logic signed [CoordW-1:0] a,
                                                 logic signed [CoordW-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return (d < 0) ? longint'(-d) : d;
  endfunction

  function automatic logic [CoordW-1:0] to_steps(logic signed [CoordW-1:0] t,
                                                 longint unsigned scale, int sh);
    longint p;
    p = (longint'(t) >>> 4) * longint'(scale);
    return CoordW'(p >>> sh);
  endfunction

  function automatic logic [IntervalW-1:0] step_interval(longint unsigned feed,
      logic signed [CoordW-1:0] tx, logic signed [CoordW-1:0] ty,
      logic signed [CoordW-1:0] tz);
    longint unsigned dx, dy, dz, st, dist_root, inv, px, py, pz, rx, ry, rz, best;
    dx = axis_delta(tx, prev_x);
    dy = axis_delta(ty, prev_y);
    dz = axis_delta(tz, prev_z);
    if (feed == 0) feed = 1;
    while (dx >= 65536 || dy >= 65536 || dz >= 65536) begin
      dx = dx >> 4;
      dy = dy >> 4;
      dz = dz >> 4;
    end
    if (dz == 0 && (dx == 0 || dy == 0 || dx + dy < 256)) begin
      if (feed > feed_xy_lim) feed = feed_xy_lim;
      st = safe_div(UsecPerMin, (feed * (scale_xy >> 4)) >> 8);
    end else if (dx == 0 && dy == 0) begin
      if (feed > feed_z_lim) feed = feed_z_lim;
      st = safe_div(UsecPerMin, (feed * scale_z) >> 8);
    end else begin
      dist_root = int_root(dx * dx + dy * dy + dz * dz);
      if (dist_root == 0) dist_root = 1;
      inv = InvNum / dist_root;
      if (inv == 0) inv = 1;
      px = (dx * inv) >> 8;
      py = (dy * inv) >> 8;
      pz = (dz * inv) >> 8;
      if (px == 0 && py == 0 && pz == 0) px = 64'd1 << 16;
      // Clamp order is Z, then Y, then X.
      if (((feed * pz) >> 16) > feed_z_lim) feed = safe_div(feed_z_lim << 16, pz);
      if (((feed * py) >> 16) > feed_xy_lim) feed = safe_div(feed_xy_lim << 16, py);
      if (((feed * px) >> 16) > feed_xy_lim) feed = safe_div(feed_xy_lim << 16, px);
      rx = (((feed * px) >> 16) * scale_xy) >> 12;
      ry = (((feed * py) >> 16) * scale_xy) >> 12;
      rz = (((feed * pz) >> 16) * scale_z) >> 8;
      best = rx;
      if (ry > best) best = ry;
      if (rz > best) best = rz;
      st = safe_div(UsecPerMin, best);
    end
    if (st == 0) st = 1;
    return st[IntervalW-1:0];
  endfunction

  function automatic step_result_t plan_point(logic [1:0] cmd,
      logic signed [CoordW-1:0] tx, logic signed [CoordW-1:0] ty,
      logic signed [CoordW-1:0] tz, longint unsigned feed);
    step_result_t r;
    r.interval = '0;
    if (cmd != CmdSetPos) begin
      if (cmd == CmdRapid)
        feed = (3 * ((feed_xy_lim > feed_z_lim) ? feed_xy_lim : feed_z_lim)) >> 2;
      r.interval = step_interval(feed, tx, ty, tz);
    end
    r.kind   = (cmd == CmdSetPos) ? KindSetPos : KindMove;
    r.step_x = to_steps(tx, scale_xy >> 2, 14);
    r.step_y = to_steps(ty, scale_xy >> 2, 14);
    r.step_z = to_steps(tz, scale_z, 12);
    prev_x = tx;
    prev_y = ty;
    prev_z = tz;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Called at a falling edge; returns at a falling edge after acceptance.
  task automatic send_point(logic [1:0] cmd, logic [CoordW-1:0] tx, logic [CoordW-1:0] ty,
                            logic [CoordW-1:0] tz, logic [FeedW-1:0] feed);
    int gap;
    s_tdata  <= {4'b0, feed, tz, ty, tx};
    s_tuser  <= cmd;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    expected_steps.push_back(plan_point(cmd, tx, ty, tz, feed));
    gen_x = tx;
    gen_y = ty;
    gen_z = tz;
    @(negedge clk);
    gap = $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Drops valid and waits until every expected result has come back.
  task automatic drain;
    s_tvalid <= 1'b0;
    while (expected_steps.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      RegMaxFeedXy: feed_xy_lim = val[FeedW-1:0];
      RegMaxFeedZ:  feed_z_lim  = val[FeedW-1:0];
      RegStepsXy:   scale_xy    = val;
      default:      scale_z     = val;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_config(logic [CfgDataW-1:0] fxy, logic [CfgDataW-1:0] fz,
                             logic [CfgDataW-1:0] sxy, logic [CfgDataW-1:0] sz);
    drain();
    write_reg(RegMaxFeedXy, fxy);
    write_reg(RegMaxFeedZ, fz);
    write_reg(RegStepsXy, sxy);
    write_reg(RegStepsZ, sz);
  endtask

  task automatic test_directed;
    logic signed [CoordW-1:0] big, neg;
    big = 32'sh7fffffff;
    neg = 32'sh80000000;
    send_point(CmdSetPos, 0, 0, 0, 0);
    send_point(CmdLinear, 0, 0, 0, 0);              // no motion at all
    send_point(CmdLinear, 32'sd2560, 0, 0, 1000);   // X only
    send_point(CmdLinear, 32'sd2560, 32'sd512, 0, 20'hfffff); // Y only
    send_point(CmdLinear, 32'sd2600, 32'sd600, 0, 3000); // short diagonal
    send_point(CmdLinear, 32'sd2600, 32'sd600, 32'sd1280, 100); // Z only
    send_point(CmdLinear, 32'sd9000, 32'sd4000, 32'sd3000, 4000); // 3-axis
    send_point(CmdRapid, 32'sd200, 32'sd100, 32'sd50, 0);
    send_point(CmdSpare, 32'sd5000, 32'sd7000, 32'sd50, 2500);
    send_point(CmdLinear, big, big, big, 20'hfffff); // large deltas, shifted down
    send_point(CmdRapid, neg, neg, neg, 0);
    send_point(CmdLinear, big, neg, 0, 1);
    send_point(CmdSetPos, neg, big, neg, 20'hfffff);
    send_point(CmdLinear, -32'sd1, -32'sd17, -32'sd16, 0);
    send_point(CmdLinear, 32'sd1, 32'sd1, 32'sd1, 20'hfffff); // tiny diagonal
    send_point(CmdRapid, 32'sd70000, 32'sd300, -32'sd70000, 7);
  endtask

  task automatic test_random(int count);
    int mode, span;
    logic [1:0] cmd;
    logic signed [CoordW-1:0] tx, ty, tz;
    logic [FeedW-1:0] feed;
    repeat (count) begin
      mode = $urandom_range(0, 9);
      span = 1 << $urandom_range(0, 20);
      tx = gen_x + $signed($urandom_range(0, 2 * span)) - span;
      ty = gen_y + $signed($urandom_range(0, 2 * span)) - span;
      tz = gen_z + $signed($urandom_range(0, span / 8 + 1)) - span / 16;
      case (mode)
        0, 1: begin
          tx = $urandom;
          ty = $urandom;
          tz = $urandom;
        end
        2: begin
          tx = gen_x;
          ty = gen_y;
        end
        3: begin
          tz = gen_z;
          if ($urandom_range(0, 1)) tx = gen_x; else ty = gen_y;
        end
        4: tz = gen_z;
        default: ;
      endcase
      cmd = 2'($urandom_range(0, 3));
      case ($urandom_range(0, 7))
        0: feed = 0;
        1: feed = 20'hfffff;
        2, 3: feed = FeedW'($urandom);
        default: feed = FeedW'($urandom_range(1, 6000));
      endcase
      send_point(cmd, tx, ty, tz, feed);
    end
  endtask

  task automatic test_backpressure;
    stall_request = 3000;
    test_random(30);
  endtask

  // Result checker with its own random back-pressure.
  initial begin
    int n;
    step_result_t got, want;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    m_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        got = {m_tuser[0], m_tdata[IntervalW+95:0]};
        if (expected_steps.size() == 0) begin
          report_mismatch("unexpected result transaction", 1, 0);
        end else begin
          want = expected_steps.pop_front();
          if (got.kind != want.kind) report_mismatch("kind", got.kind, want.kind);
          if (got.step_x != want.step_x) report_mismatch("step_x", got.step_x, want.step_x);
          if (got.step_y != want.step_y) report_mismatch("step_y", got.step_y, want.step_y);
          if (got.step_z != want.step_z) report_mismatch("step_z", got.step_z, want.step_z);
          if (got.interval != want.interval)
            report_mismatch("step_interval_us", got.interval, want.interval);
        end
        n = $urandom_range(0, 19);
        if ($urandom_range(0, 3) == 0) n = 0;
        if (stall_request > 0) begin
          n = stall_request;
          stall_request = 0;
        end
        @(negedge clk);
        if (n > 0) begin
          m_tready <= 1'b0;
          repeat (n) @(negedge clk);
          m_tready <= 1'b1;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("FAIL move_step_interval_planner_unit");
      $finish;
    end
  end

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    feed_xy_lim = MaxFeedXyRst;
    feed_z_lim  = MaxFeedZRst;
    scale_xy    = StepsXyRst;
    scale_z     = StepsZRst;
    prev_x = 0; prev_y = 0; prev_z = 0;
    gen_x = 0; gen_y = 0; gen_z = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_directed();
    test_random(330);
    test_backpressure();
    load_config(24'hfffff, 24'hfffff, 24'hffffff, 24'hffffff);
    test_directed();
    test_random(320);
    load_config(1, 1, 1, 1);
    test_directed();
    test_random(320);
    load_config(0, 0, 0, 0);
    test_random(60);
    load_config(CfgDataW'($urandom_range(1, 20000)), CfgDataW'($urandom_range(1, 2000)),
                CfgDataW'($urandom_range(4096, 200000)),
                CfgDataW'($urandom_range(256, 200000)));
    test_random(320);

    drain();
    repeat (1000) @(posedge clk);
    if (error_count == 0)
      $display("PASS move_step_interval_planner_unit");
    else
      $display("FAIL move_step_interval_planner_unit");
    $finish;
  end

endmodule
